// ===== sv/tpdl_pkg.sv =====
// Shared types and constants for the tree path distance block.
// Holds the word structs, memory entry types, state enum and a log2 helper.
package tpdl_pkg;

    localparam int NODE_W = 10;
    localparam int DEPTH_W = 10;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W = 26;
    localparam int DIST_W = 27;
    localparam int LV_W = 4;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [NODE_W-1:0]   first_node;
        logic [NODE_W-1:0]   second_node;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              status;
    } t_out_word;

    typedef struct packed {
        logic               present;
        logic [DEPTH_W-1:0] depth;
    } t_node;

    typedef struct packed {
        logic [NODE_W-1:0] anc;
        logic [SUM_W-1:0]  sum;
    } t_jump;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RA,
        S_RB,
        S_CHK,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_LIFT,
        S_Q_LDAT,
        S_Q_SEL,
        S_Q_RV,
        S_Q_CMP,
        S_OUT
    } t_state;

    function automatic logic [LV_W-1:0] floor_log2(input logic [DEPTH_W-1:0] x);
        logic [LV_W-1:0] r;
        r = '0;
        for (int i = 1; i < DEPTH_W; i++) begin
            if (x[i]) begin
                r = LV_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/tree_path_distance_lifting.sv =====
// Weighted tree with binary lifting tables; adds nodes, answers path distances.
// Depends on tpdl_pkg. Node table and jump table are single-port-read memories.
// After reset a clearing pass over the node table runs before the first word is
// taken. An add does one jump-table read and write per level; a query lifts the
// deeper node step by step, then descends jointly over the levels, comparing some
// and skipping others, and adds the final edges, the jump-table read port setting
// the pace.
// One word at a time; a finished result waits in the output register while the next
// word is taken.
module tree_path_distance_lifting
    import tpdl_pkg::*;
#(
    parameter int NODE_COUNT = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int LW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int JW = NW + LW;
    localparam int JDEPTH = NODE_COUNT << LW;

    t_node m_node [NODE_COUNT];
    t_jump m_jump [JDEPTH];

    logic          node_we;
    logic [NW-1:0] node_wa;
    t_node         node_wd;
    logic [NW-1:0] node_ra;
    t_node         node_rd;
    logic          jump_we;
    logic [JW-1:0] jump_wa;
    t_jump         jump_wd;
    logic [JW-1:0] jump_ra;
    t_jump         jump_rd;

    t_state r_state, n_state;
    logic [NW-1:0]       r_clr, n_clr;
    logic                r_kind, n_kind;
    logic [NODE_W-1:0]   r_a, n_a, r_b, n_b;
    logic [WEIGHT_W-1:0] r_w, n_w;
    t_node               r_na, n_na;
    logic [NODE_W-1:0]   r_u, n_u, r_v, n_v, r_anc, n_anc;
    logic [DEPTH_W-1:0]  r_du, n_du, r_dv, n_dv;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [LV_W-1:0]     r_lv, n_lv, r_top, n_top;
    logic                r_fin, n_fin;
    logic [DIST_W-1:0]   r_acc, n_acc;
    t_jump               r_ju, n_ju;
    logic                r_err, n_err;
    logic                r_ovalid, n_ovalid;
    t_out_word           r_out, n_out;

    logic               in_fire, out_free;
    logic               a_in, b_in, ok_add, ok_q;
    logic [DEPTH_W-1:0] new_depth;
    logic [15:0]        pow;
    logic               pow_gt;

    function automatic logic [LV_W-1:0] cap_lv(input logic [LV_W-1:0] lv);
        return (32'(lv) > LIFT_LEVELS - 1) ? LV_W'(LIFT_LEVELS - 1) : lv;
    endfunction

    function automatic logic [JW-1:0] jaddr(input logic [NODE_W-1:0] n,
                                           input logic [LV_W-1:0] lv);
        return {NW'(n), LW'(lv)};
    endfunction

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign a_in     = 32'(r_a) < NODE_COUNT;
    assign b_in     = 32'(r_b) < NODE_COUNT;
    assign ok_add   = (r_a != '0) && a_in && !r_na.present && b_in && node_rd.present;
    assign ok_q     = a_in && r_na.present && b_in && node_rd.present;
    assign new_depth = node_rd.depth + DEPTH_W'(1);
    assign pow      = 16'(1) << r_lv;
    assign pow_gt   = pow > 16'(r_du);

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            m_node[node_wa] <= node_wd;
        end
        node_rd <= m_node[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (jump_we) begin
            m_jump[jump_wa] <= jump_wd;
        end
        jump_rd <= m_jump[jump_ra];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:    if (32'(r_clr) == NODE_COUNT - 1) n_state = S_IDLE;
            S_IDLE:   if (in_fire) n_state = S_RA;
            S_RA:     n_state = S_RB;
            S_RB:     n_state = S_CHK;
            S_CHK: begin
                if (r_kind == KIND_ADD) begin
                    if (!ok_add || cap_lv(floor_log2(new_depth)) == '0) n_state = S_OUT;
                    else n_state = S_ADD_RD;
                end else begin
                    n_state = ok_q ? S_Q_LIFT : S_OUT;
                end
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: if (r_lv == r_top) n_state = S_OUT; else n_state = S_ADD_RD;
            S_Q_LIFT: begin
                if (r_du > r_dv) n_state = S_Q_LDAT;
                else if (r_u == r_v) n_state = S_OUT;
                else n_state = S_Q_SEL;
            end
            S_Q_LDAT: n_state = S_Q_LIFT;
            S_Q_SEL:  if (r_fin || !pow_gt) n_state = S_Q_RV;
            S_Q_RV:   n_state = S_Q_CMP;
            S_Q_CMP:  n_state = r_fin ? S_OUT : S_Q_SEL;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr; n_kind = r_kind; n_a = r_a; n_b = r_b; n_w = r_w; n_na = r_na;
        n_u = r_u; n_v = r_v; n_anc = r_anc; n_du = r_du; n_dv = r_dv; n_sum = r_sum;
        n_lv = r_lv; n_top = r_top; n_fin = r_fin; n_acc = r_acc; n_ju = r_ju;
        n_err = r_err; n_out = r_out;
        n_ovalid = r_ovalid && !i_out_ready;
        node_we = 1'b0; node_wa = NW'(r_a); node_wd = '0; node_ra = NW'(r_a);
        jump_we = 1'b0; jump_wa = jaddr(r_a, r_lv); jump_wd = '0;
        jump_ra = jaddr(r_u, r_lv);
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                node_we = 1'b1;
                node_wa = r_clr;
                node_wd = '{present: (r_clr == '0), depth: '0};
                n_clr = r_clr + NW'(1);
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    n_kind = i_in_word.kind;
                    n_a = i_in_word.first_node;
                    n_b = i_in_word.second_node;
                    n_w = i_in_word.edge_weight;
                    n_acc = '0;
                    n_err = 1'b0;
                end
            end
            S_RA: node_ra = NW'(r_a);
            S_RB: begin
                node_ra = NW'(r_b);
                n_na = node_rd;
            end
            S_CHK: begin
                if (r_kind == KIND_ADD) begin
                    n_err = !ok_add;
                    if (ok_add) begin
                        node_we = 1'b1;
                        node_wa = NW'(r_a);
                        node_wd = '{present: 1'b1, depth: new_depth};
                        jump_we = 1'b1;
                        jump_wa = jaddr(r_a, '0);
                        jump_wd = '{anc: r_b, sum: SUM_W'(r_w)};
                        n_anc = r_b;
                        n_sum = SUM_W'(r_w);
                        n_top = cap_lv(floor_log2(new_depth));
                        n_lv = LV_W'(1);
                    end
                end else begin
                    n_err = !ok_q;
                    if (r_na.depth < node_rd.depth) begin
                        n_u = r_b; n_du = node_rd.depth;
                        n_v = r_a; n_dv = r_na.depth;
                    end else begin
                        n_u = r_a; n_du = r_na.depth;
                        n_v = r_b; n_dv = node_rd.depth;
                    end
                end
            end
            S_ADD_RD: jump_ra = jaddr(r_anc, r_lv - LV_W'(1));
            S_ADD_WR: begin
                n_anc = jump_rd.anc;
                n_sum = r_sum + jump_rd.sum;
                jump_we = 1'b1;
                jump_wa = jaddr(r_a, r_lv);
                jump_wd = '{anc: jump_rd.anc, sum: r_sum + jump_rd.sum};
                n_lv = r_lv + LV_W'(1);
            end
            S_Q_LIFT: begin
                if (r_du > r_dv) begin
                    n_lv = cap_lv(floor_log2(r_du - r_dv));
                    jump_ra = jaddr(r_u, cap_lv(floor_log2(r_du - r_dv)));
                end else begin
                    n_lv = cap_lv(floor_log2(r_du));
                    n_fin = 1'b0;
                end
            end
            S_Q_LDAT: begin
                n_acc = r_acc + DIST_W'(jump_rd.sum);
                n_u = jump_rd.anc;
                n_du = r_du - DEPTH_W'(pow);
            end
            S_Q_SEL: begin
                jump_ra = jaddr(r_u, r_lv);
                if (!r_fin && pow_gt) begin
                    if (r_lv == '0) n_fin = 1'b1;
                    else n_lv = r_lv - LV_W'(1);
                end
            end
            S_Q_RV: begin
                jump_ra = jaddr(r_v, r_lv);
                n_ju = jump_rd;
            end
            S_Q_CMP: begin
                if (r_fin) begin
                    n_acc = r_acc + DIST_W'(r_ju.sum) + DIST_W'(jump_rd.sum);
                end else begin
                    if (r_ju.anc != jump_rd.anc) begin
                        n_acc = r_acc + DIST_W'(r_ju.sum) + DIST_W'(jump_rd.sum);
                        n_u = r_ju.anc;
                        n_v = jump_rd.anc;
                        n_du = r_du - DEPTH_W'(pow);
                    end
                    if (r_lv == '0) n_fin = 1'b1;
                    else n_lv = r_lv - LV_W'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out.distance = r_err ? '0 : r_acc;
                    n_out.status = r_err;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_a <= n_a; r_b <= n_b; r_w <= n_w; r_na <= n_na;
        r_u <= n_u; r_v <= n_v; r_anc <= n_anc; r_du <= n_du; r_dv <= n_dv;
        r_sum <= n_sum; r_lv <= n_lv; r_top <= n_top; r_fin <= n_fin;
        r_acc <= n_acc; r_ju <= n_ju; r_err <= n_err; r_out <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_in_ready)
        else $error("word taken during clearing pass");

    a_err_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status |-> o_out_word.distance == '0)
        else $error("error result with nonzero distance");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_RA)
        else $error("word taken without starting work");

endmodule
